@@ src/rlhr_pkg.sv @@
// shared types and constants for the rate limited history ring
package rlhr_pkg;

   localparam int DEPTH    = 64;
   localparam int SAMPLE_W = 32;
   localparam int TIME_W   = 32;
   localparam int IVL_W    = 16;
   localparam int CNT_W    = 7;
   localparam int FILL_W   = $clog2(DEPTH + 1);
   localparam int MAX_READ = 64;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic push;
      logic rotate;
   } cell_ctl_type;

endpackage

@@ src/rate_limited_history_ring.sv @@
// top level of the rate limited history ring
//
// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tuser command, tdata value/timestamp/count
// rsp      out  rsp_tvalid/tready     tdata entry_value, tuser present, tlast
// csr      in   csr_tvalid/tready     tdata min_interval_ms
//
// a push that the gate keeps puts the newest sample into cell 0 and the chain shifts up
// a read keeps req_tready low after its transfer until the chain has rotated once
// around, cell 0 giving one position per cycle while no rsp stall holds it, which restores the order at the end
// rsp stalls freeze the rotation while a result is still to be emitted
// synchronous reset clears gate, fill count and control; cells start undefined
module rate_limited_history_ring import rlhr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [71:0]      req_tdata,   // sample_value, timestamp_ms, read_count, pad
   input  logic             req_tuser,   // command
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,   // entry_value
   output logic             rsp_tuser,   // entry_present
   output logic             rsp_tlast,
   input  logic             csr_tvalid,
   output logic             csr_tready,
   input  logic [15:0]      csr_tdata    // min_interval_ms
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_READ);

   logic [IVL_W-1:0]    interval_ff;
   logic                busy_ff;
   logic                busy_in;
   logic [CNT_W-1:0]    step_ff;
   logic [CNT_W-1:0]    step_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_value_ff;
   logic [SAMPLE_W-1:0] rsp_value_in;
   logic                rsp_present_ff;
   logic                rsp_present_in;
   logic                rsp_last_ff;
   logic                rsp_last_in;

   logic                req_take;
   logic                push_take;
   logic                read_take;
   logic                keep;
   logic [FILL_W-1:0]   fill_count;
   logic [CNT_W-1:0]    req_count;
   logic                emit_needed;
   logic                rot_needed;
   logic                advance;
   logic [CNT_W-1:0]    step_next;
   logic                present;
   cell_ctl_type        ctl;
   logic [SAMPLE_W-1:0] cell_q [DEPTH];

   assign req_tready = !busy_ff;
   assign csr_tready = 1'b1;
   assign req_take   = req_tvalid && req_tready;
   assign push_take  = req_take && (req_tuser == CMD_PUSH);
   assign read_take  = req_take && (req_tuser == CMD_READ);
   assign req_count  = req_tdata[70:64];

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
      end else if (csr_tvalid && csr_tready) begin
         interval_ff <= csr_tdata;
      end
   end

   rlhr_gate u_gate (
      .clock        (clock),
      .reset        (reset),
      .push_take    (push_take),
      .timestamp    (req_tdata[63:32]),
      .min_interval (interval_ff),
      .keep         (keep),
      .fill_count   (fill_count)
   );

   assign emit_needed = step_ff < count_ff;
   assign rot_needed  = step_ff < DEPTH_CNT;
   assign advance     = busy_ff && (!emit_needed || !rsp_valid_ff || rsp_tready);
   assign step_next   = step_ff + 1'b1;
   assign present     = step_ff < CNT_W'(fill_count);

   assign ctl.push   = keep;
   assign ctl.rotate = advance && rot_needed;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      rlhr_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .lower_data ((k == 0) ? req_tdata[31:0] : cell_q[(k + DEPTH - 1) % DEPTH]),
         .upper_data (cell_q[(k + 1) % DEPTH]),
         .cell_data  (cell_q[k])
      );
   end

   always_comb begin
      busy_in        = busy_ff;
      step_in        = step_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_present_in = rsp_present_ff;
      rsp_last_in    = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (read_take) begin
         busy_in  = 1'b1;
         step_in  = '0;
         count_in = (req_count > MAX_CNT) ? MAX_CNT : req_count;
      end
      if (advance) begin
         step_in = step_next;
         if (emit_needed) begin
            rsp_valid_in   = 1'b1;
            rsp_present_in = present;
            rsp_value_in   = present ? cell_q[0] : '0;
            rsp_last_in    = (step_next == count_ff);
         end
         if ((step_next >= count_ff) && (step_next >= DEPTH_CNT)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff   <= rsp_value_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_present_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ src/rlhr_cell.sv @@
// one storage cell of the history chain
module rlhr_cell import rlhr_pkg::*; (
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic [SAMPLE_W-1:0] lower_data,
   input  logic [SAMPLE_W-1:0] upper_data,
   output logic [SAMPLE_W-1:0] cell_data
);

   logic [SAMPLE_W-1:0] value_ff;
   logic [SAMPLE_W-1:0] value_in;

   always_comb begin
      priority if (ctl.push) begin
         value_in = lower_data;
      end else if (ctl.rotate) begin
         value_in = upper_data;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_data = value_ff;

endmodule

@@ src/rlhr_gate.sv @@
// rate gate for pushes: last kept time and fill count
module rlhr_gate import rlhr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_take,
   input  logic [TIME_W-1:0] timestamp,
   input  logic [IVL_W-1:0]  min_interval,
   output logic              keep,
   output logic [FILL_W-1:0] fill_count
);

   logic [TIME_W-1:0] last_time_ff;
   logic [TIME_W-1:0] last_time_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [TIME_W-1:0] diff;

   assign diff = timestamp - last_time_ff;
   assign keep = push_take && !diff[TIME_W-1]
                 && (diff >= {{(TIME_W-IVL_W){1'b0}}, min_interval});

   always_comb begin
      last_time_in = last_time_ff;
      fill_in      = fill_ff;
      if (keep) begin
         last_time_in = timestamp;
         if (fill_ff != FILL_W'(DEPTH)) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         fill_ff      <= '0;
      end else begin
         last_time_ff <= last_time_in;
         fill_ff      <= fill_in;
      end
   end

   assign fill_count = fill_ff;

endmodule

@@ test/rate_limited_history_ring_test.sv @@
// self-checking testbench for the rate limited history ring
module rate_limited_history_ring_test import rlhr_pkg::*;;

   localparam int CYCLE_LIMIT  = 8000000;
   localparam int SETTLE_WAIT  = 150;
   localparam int PHASE_ITEMS  = 120;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 600;

   typedef struct packed {
      logic                cmd;
      logic [SAMPLE_W-1:0] value;
      logic [TIME_W-1:0]   stamp;
      logic [CNT_W-1:0]    count;
      logic                typed;
      logic [SAMPLE_W-1:0] exp_value;
      logic                exp_present;
   } ring_item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                present;
      logic                is_last;
   } ring_entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [71:0]      req_tdata = '0;   // sample_value, timestamp_ms, read_count, pad
   logic             req_tuser = 1'b0; // command
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [31:0]      rsp_tdata;        // entry_value
   logic             rsp_tuser;        // entry_present
   logic             rsp_tlast;
   logic             csr_tvalid = 1'b0;
   logic             csr_tready;
   logic [15:0]      csr_tdata = '0;   // min_interval_ms

   rate_limited_history_ring dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the ring state
   logic [SAMPLE_W-1:0] shadow_store [DEPTH];
   logic [5:0]          shadow_wr_ptr = '0;
   logic [FILL_W-1:0]   shadow_fill = '0;
   logic [TIME_W-1:0]   shadow_last_time = '0;
   logic [IVL_W-1:0]    shadow_interval = '0;

   ring_entry_type pending_entries [$];

   logic [TIME_W-1:0] stream_ts = '0;
   int error_count = 0;
   int results_seen = 0;
   int items_sent = 0;
   int reads_sent = 0;
   int pushes_kept = 0;
   int settings_used = 0;
   int cycle_count = 0;
   bit long_hold_done = 1'b0;

   ring_item_type directed_rows [21] = '{
      '{CMD_READ, 32'h0000_0000, 32'h0000_0000, 7'd0,   1'b1, 32'h0000_0000, 1'b0},
      '{CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd3,   1'b1, 32'h0000_0000, 1'b0},
      '{CMD_PUSH, 32'h7FFF_FFFF, 32'd50,        7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_READ, 32'h0000_0000, 32'h0000_0000, 7'd1,   1'b1, 32'h0000_0000, 1'b0},
      '{CMD_PUSH, 32'h8000_0000, 32'd100,       7'd127, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_READ, 32'h0000_0000, 32'h0000_0000, 7'd1,   1'b1, 32'h8000_0000, 1'b1},
      '{CMD_PUSH, 32'h1234_5678, 32'd199,       7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_PUSH, 32'h0000_0000, 32'd40,        7'd64,  1'b0, 32'h0000_0000, 1'b0},
      '{CMD_PUSH, 32'h7FFF_FFFF, 32'd200,       7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_READ, 32'h0000_0000, 32'h0000_0000, 7'd1,   1'b1, 32'h7FFF_FFFF, 1'b1},
      '{CMD_READ, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 7'd2,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_PUSH, 32'h0000_0001, 32'h8000_00C7, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_PUSH, 32'h0001_0000, 32'h8000_012B, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_READ, 32'h0000_0000, 32'h0000_0000, 7'd127, 1'b0, 32'h0000_0000, 1'b0},
      '{CMD_READ, 32'h0000_0000, 32'h0000_0000, 7'd64,  1'b0, 32'h0000_0000, 1'b0},
      '{CMD_READ, 32'h0000_0000, 32'h0000_0000, 7'd65,  1'b0, 32'h0000_0000, 1'b0},
      '{CMD_PUSH, 32'hFFFF_0000, 32'hFFFF_FFFF, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_PUSH, 32'h0000_0000, 32'h0000_0063, 7'd0,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_READ, 32'h0000_0000, 32'h0000_0000, 7'd5,   1'b0, 32'h0000_0000, 1'b0},
      '{CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0,   1'b0, 32'h0000_0000, 1'b0}
   };

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // gate, store and read-out of the ring for one accepted item
   task automatic apply_ring_item(input ring_item_type it, output bit kept);
      logic [TIME_W-1:0] diff;
      logic [5:0]        idx;
      ring_entry_type    ent;
      int                n;
      kept = 1'b0;
      if (it.cmd == CMD_PUSH) begin
         diff = it.stamp - shadow_last_time;
         if (!diff[TIME_W-1] && diff >= {16'd0, shadow_interval}) begin
            kept = 1'b1;
            shadow_last_time = it.stamp;
            shadow_store[shadow_wr_ptr] = it.value;
            shadow_wr_ptr = shadow_wr_ptr + 6'd1;
            if (shadow_fill < DEPTH) shadow_fill = shadow_fill + 1'b1;
         end
      end else begin
         n = (it.count > MAX_READ) ? MAX_READ : int'(it.count);
         for (int i = 0; i < n; i++) begin
            if (it.typed) begin
               ent.value   = it.exp_value;
               ent.present = it.exp_present;
            end else if (i < shadow_fill) begin
               idx = shadow_wr_ptr - 6'd1 - 6'(i);
               ent.value   = shadow_store[idx];
               ent.present = 1'b1;
            end else begin
               ent.value   = '0;
               ent.present = 1'b0;
            end
            ent.is_last = (i == n - 1);
            pending_entries.push_back(ent);
         end
      end
   endtask

   task automatic send_item(input ring_item_type it, output bit kept);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {1'b0, it.count, it.stamp, it.value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_ring_item(it, kept);
      items_sent++;
      if (it.cmd == CMD_READ) reads_sent++;
      if (kept) pushes_kept++;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_interval(input logic [IVL_W-1:0] ivl);
      csr_tvalid <= 1'b1;
      csr_tdata  <= ivl;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      shadow_interval = ivl;
      settings_used++;
      csr_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly pushes that step near the interval, plus back steps, jumps and reads
   task automatic random_item(output ring_item_type it);
      int r;
      int d;
      it = '0;
      it.value = $urandom;
      it.count = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 99) < 65) begin
         it.cmd = CMD_PUSH;
         r = $urandom_range(0, 99);
         if (r < 70) begin
            d = int'(shadow_interval) + int'($urandom_range(0, 20)) - 10;
            stream_ts = stream_ts + 32'(d);
         end else if (r < 85) begin
            stream_ts = stream_ts + {16'd0, shadow_interval};
         end else if (r < 92) begin
            stream_ts = stream_ts - 32'($urandom_range(1, 1000));
         end else begin
            stream_ts = $urandom;
         end
         it.stamp = stream_ts;
      end else begin
         it.cmd   = CMD_READ;
         it.stamp = $urandom;
         r = $urandom_range(0, 99);
         if (r < 10)      it.count = 7'd0;
         else if (r < 60) it.count = 7'($urandom_range(1, 8));
         else if (r < 85) it.count = 7'($urandom_range(9, 64));
         else if (r < 95) it.count = 7'($urandom_range(65, 127));
         else             it.count = 7'd64;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("error: %s got %h expected %h at result %0d", what, got, want,
               results_seen);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      ring_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_entries.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_tdata, 32'd0);
         end else begin
            want = pending_entries.pop_front();
            if (rsp_tdata !== want.value)
               report_mismatch("entry_value", rsp_tdata, want.value);
            if (rsp_tuser !== want.present)
               report_mismatch("entry_present", 32'(rsp_tuser), 32'(want.present));
            if (rsp_tlast !== want.is_last)
               report_mismatch("last_in_run", 32'(rsp_tlast), 32'(want.is_last));
         end
         results_seen++;
      end
   end

   // result side backpressure
   initial begin
      int stall;
      @(negedge reset);
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat (200) @(posedge clock);
         else repeat ($urandom_range(1, 40)) @(posedge clock);
         stall = pick_gap();
         if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            stall = HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rate_limited_history_ring: mismatch");
         $finish;
      end
   end

   initial begin
      logic [IVL_W-1:0] phase_ivl [4];
      ring_item_type it;
      bit kept;
      phase_ivl[0] = 16'd0;
      phase_ivl[1] = 16'hFFFF;
      phase_ivl[2] = 16'($urandom_range(2, 5000));
      phase_ivl[3] = 16'd1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_interval(16'd100);
      foreach (directed_rows[k]) send_item(directed_rows[k], kept);
      for (int p = 0; p < 4; p++) begin
         settle();
         write_interval(phase_ivl[p]);
         repeat (PHASE_ITEMS) begin
            random_item(it);
            send_item(it, kept);
         end
      end
      settle();
      $display("run covered %0d items (%0d reads, %0d kept pushes), %0d results checked",
               items_sent, reads_sent, pushes_kept, results_seen);
      $display("interval register written %0d times, long result stall applied: %0d",
               settings_used, long_hold_done);
      if (error_count == 0 && pending_entries.size() == 0) begin
         $display("rate_limited_history_ring: match");
      end else begin
         $display("rate_limited_history_ring: mismatch");
      end
      $finish;
   end

endmodule
